// ===== src/blu5_pkg.sv =====
// ----------------------------------------------------------------------------
// blu5_pkg
// Shared types and constants of the 5x bilinear upscaler: the cell record
// passed from the front end through the cell queue to the output sequencer.
// ----------------------------------------------------------------------------
package blu5_pkg;

    // Field widths
    localparam int PIX_W      = 8;
    localparam int SUB_W      = 3;
    localparam int CELL_COL_W = 7;
    localparam int CFG_W      = 8;

    // Reset row width of the source image
    localparam logic [CFG_W-1:0] RESET_SOURCE_WIDTH = 8'd104;
    localparam int               MIN_WIDTH          = 2;

    // Sub-position range inside one 5x5 block
    localparam logic [SUB_W-1:0] SUB_FIVE = 3'd5;
    localparam logic [SUB_W-1:0] SUB_LAST = 3'd4;

    // Weighted sum: 25 * 255 fits in 13 bits
    localparam int WGT_W = 5;
    localparam int SUM_W = 13;

    // floor(x/25) = (x * ceil(2^20/25)) >> 20, exact for x < 6400
    localparam int                 RECIP_W     = 16;
    localparam int                 RECIP_SHIFT = 20;
    localparam logic [RECIP_W-1:0] RECIP_25    = 16'd41944;

    // Cell queue depth between front and back
    localparam int QUEUE_DEPTH = 4;

    // One closed 2x2 cell
    typedef struct packed {
        logic [PIX_W-1:0]      p00;
        logic [PIX_W-1:0]      p01;
        logic [PIX_W-1:0]      p10;
        logic [PIX_W-1:0]      p11;
        logic [CELL_COL_W-1:0] cell_col;
    } t_cell;

    // Queue status toward front and back
    typedef struct packed {
        logic empty;
        logic room;
    } t_q_stat;

endpackage

// ===== src/blu5_front.sv =====
// ----------------------------------------------------------------------------
// blu5_front
// Takes source pixels, tracks column and row, keeps the previous row in a
// line store and forms the 2x2 cell that each pixel past row 0 / col 0 closes.
// ----------------------------------------------------------------------------
module blu5_front #(
    parameter int MAX_WIDTH = 128
) (
    input  logic                          i_clk,
    input  logic                          i_rst_n,
    input  logic [blu5_pkg::CFG_W-1:0]    i_source_width,
    input  logic                          i_valid,
    input  logic [blu5_pkg::PIX_W-1:0]    i_pixel,
    input  logic                          i_frame_start,
    output logic                          o_ready,
    input  blu5_pkg::t_q_stat             i_q_stat,
    output logic                          o_push,
    output blu5_pkg::t_cell               o_cell
);

    localparam int AW = (MAX_WIDTH > 1) ? $clog2(MAX_WIDTH) : 1;
    localparam int CW = $clog2(MAX_WIDTH + 1);

    logic [blu5_pkg::PIX_W-1:0] r_line [MAX_WIDTH];
    logic [blu5_pkg::PIX_W-1:0] r_rd_data;

    logic [AW-1:0]              r_col_cnt;
    logic                       r_past_row;
    logic [blu5_pkg::PIX_W-1:0] r_left;

    // Stage B: the cycle after acceptance, waiting on the line store read
    logic                            r_b_vld;
    logic                            r_b_emit;
    logic [blu5_pkg::PIX_W-1:0]      r_b_px;
    logic [blu5_pkg::PIX_W-1:0]      r_b_p10;
    logic [blu5_pkg::PIX_W-1:0]      r_b_ul;
    logic [blu5_pkg::CELL_COL_W-1:0] r_b_cell_col;

    logic [CW-1:0]  eff_w;
    logic [AW-1:0]  cnt;
    logic           past;
    logic           wrap;
    logic [AW-1:0]  col;
    logic           past_now;
    logic           emit;
    logic [CW-1:0]  col_inc;
    logic [AW-1:0]  col_m1;
    logic           accept;
    logic [AW-1:0]  n_col_cnt;
    logic           n_past_row;

    assign o_ready = i_q_stat.room;
    assign accept  = i_valid && o_ready;

    // Clamp configured width to [2, MAX_WIDTH]
    always_comb begin
        if (int'(i_source_width) < blu5_pkg::MIN_WIDTH) begin
            eff_w = CW'(blu5_pkg::MIN_WIDTH);
        end else if (int'(i_source_width) > MAX_WIDTH) begin
            eff_w = CW'(MAX_WIDTH);
        end else begin
            eff_w = CW'(i_source_width);
        end
    end

    // Column position of the incoming pixel and next counter state
    always_comb begin
        cnt      = i_frame_start ? '0 : r_col_cnt;
        past     = i_frame_start ? 1'b0 : r_past_row;
        wrap     = (CW'(cnt) >= eff_w);
        col      = wrap ? '0 : cnt;
        past_now = wrap || past;
        emit     = past_now && (col != '0);
        col_m1   = col - AW'(1);
        col_inc  = CW'(col) + CW'(1);
        if (col_inc >= eff_w) begin
            n_col_cnt  = '0;
            n_past_row = 1'b1;
        end else begin
            n_col_cnt  = AW'(col_inc);
            n_past_row = past_now;
        end
    end

    // Line store: read-first, one port
    always_ff @(posedge i_clk) begin
        if (accept) begin
            r_rd_data  <= r_line[col];
            r_line[col] <= i_pixel;
        end
    end

    // Counters and left pixel
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_col_cnt  <= '0;
            r_past_row <= 1'b0;
            r_left     <= '0;
            r_b_vld    <= 1'b0;
        end else begin
            r_b_vld <= accept;
            if (accept) begin
                r_col_cnt  <= n_col_cnt;
                r_past_row <= n_past_row;
                r_left     <= i_pixel;
            end
        end
    end

    // Stage B payload; upper-left is the previous pixel's above value
    always_ff @(posedge i_clk) begin
        if (accept) begin
            r_b_emit     <= emit;
            r_b_px       <= i_pixel;
            r_b_p10      <= r_left;
            r_b_ul       <= r_rd_data;
            r_b_cell_col <= blu5_pkg::CELL_COL_W'(col_m1);
        end
    end

    // Push closed cell into queue
    assign o_push        = r_b_vld && r_b_emit;
    assign o_cell.p00    = r_b_ul;
    assign o_cell.p01    = r_rd_data;
    assign o_cell.p10    = r_b_p10;
    assign o_cell.p11    = r_b_px;
    assign o_cell.cell_col = r_b_cell_col;

endmodule

// ===== src/blu5_queue.sv =====
// ----------------------------------------------------------------------------
// blu5_queue
// Small cell FIFO between front end and output sequencer. Room is reported
// with one slot in reserve for the cell still in the front's read stage.
// ----------------------------------------------------------------------------
module blu5_queue (
    input  logic              i_clk,
    input  logic              i_rst_n,
    input  logic              i_push,
    input  blu5_pkg::t_cell   i_cell,
    input  logic              i_pop,
    output blu5_pkg::t_cell   o_head,
    output blu5_pkg::t_q_stat o_stat
);

    localparam int DEPTH = blu5_pkg::QUEUE_DEPTH;
    localparam int PW    = $clog2(DEPTH);
    localparam int NW    = $clog2(DEPTH + 1);

    blu5_pkg::t_cell r_mem [DEPTH];
    logic [PW-1:0]   r_wr_ptr;
    logic [PW-1:0]   r_rd_ptr;
    logic [NW-1:0]   r_count;

    // Storage
    always_ff @(posedge i_clk) begin
        if (i_push) begin
            r_mem[r_wr_ptr] <= i_cell;
        end
    end

    // Pointers and fill count
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_wr_ptr <= '0;
            r_rd_ptr <= '0;
            r_count  <= '0;
        end else begin
            if (i_push) begin
                r_wr_ptr <= r_wr_ptr + PW'(1);
            end
            if (i_pop) begin
                r_rd_ptr <= r_rd_ptr + PW'(1);
            end
            unique case ({i_push, i_pop})
                2'b10:   r_count <= r_count + NW'(1);
                2'b01:   r_count <= r_count - NW'(1);
                default: r_count <= r_count;
            endcase
        end
    end

    assign o_head       = r_mem[r_rd_ptr];
    assign o_stat.empty = (r_count == '0);
    assign o_stat.room  = (r_count <= NW'(DEPTH - 2));

endmodule

// ===== src/blu5_back.sv =====
// ----------------------------------------------------------------------------
// blu5_back
// Output sequencer: walks the 5x5 sub-positions of the head cell, forms the
// weighted sum, divides by 25 through a reciprocal multiply, and holds the
// result in an output register.
// ----------------------------------------------------------------------------
module blu5_back (
    input  logic                                i_clk,
    input  logic                                i_rst_n,
    input  blu5_pkg::t_cell                     i_head,
    input  blu5_pkg::t_q_stat                   i_q_stat,
    output logic                                o_pop,
    output logic                                o_valid,
    input  logic                                i_ready,
    output logic [blu5_pkg::PIX_W-1:0]          o_value,
    output logic [blu5_pkg::SUB_W-1:0]          o_sub_row,
    output logic [blu5_pkg::SUB_W-1:0]          o_sub_col,
    output logic [blu5_pkg::CELL_COL_W-1:0]     o_cell_col,
    output logic                                o_block_last
);

    localparam int PW = blu5_pkg::SUM_W + blu5_pkg::RECIP_W;

    logic [blu5_pkg::SUB_W-1:0] r_sub_row;
    logic [blu5_pkg::SUB_W-1:0] r_sub_col;

    // Sum stage
    logic                            r_s1_vld;
    logic [blu5_pkg::SUM_W-1:0]      r_s1_sum;
    logic [blu5_pkg::SUB_W-1:0]      r_s1_row;
    logic [blu5_pkg::SUB_W-1:0]      r_s1_col;
    logic [blu5_pkg::CELL_COL_W-1:0] r_s1_cell_col;
    logic                            r_s1_last;

    // Output register
    logic                            r_o_vld;
    logic [blu5_pkg::PIX_W-1:0]      r_o_value;
    logic [blu5_pkg::SUB_W-1:0]      r_o_row;
    logic [blu5_pkg::SUB_W-1:0]      r_o_col;
    logic [blu5_pkg::CELL_COL_W-1:0] r_o_cell_col;
    logic                            r_o_last;

    logic                            adv;
    logic                            issue;
    logic                            last_pos;
    logic [blu5_pkg::SUB_W-1:0]      wi0;
    logic [blu5_pkg::SUB_W-1:0]      wj0;
    logic [blu5_pkg::WGT_W-1:0]      w00;
    logic [blu5_pkg::WGT_W-1:0]      w01;
    logic [blu5_pkg::WGT_W-1:0]      w10;
    logic [blu5_pkg::WGT_W-1:0]      w11;
    logic [blu5_pkg::SUM_W-1:0]      n_sum;
    logic [PW-1:0]                   prod;

    // Pipeline moves when the output register is free or being taken
    assign adv      = !r_o_vld || i_ready;
    assign issue    = adv && !i_q_stat.empty;
    assign last_pos = (r_sub_row == blu5_pkg::SUB_LAST) && (r_sub_col == blu5_pkg::SUB_LAST);
    assign o_pop    = issue && last_pos;

    // Sub-position counters, column inner
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_sub_row <= '0;
            r_sub_col <= '0;
        end else if (issue) begin
            if (r_sub_col == blu5_pkg::SUB_LAST) begin
                r_sub_col <= '0;
                r_sub_row <= last_pos ? '0 : r_sub_row + blu5_pkg::SUB_W'(1);
            end else begin
                r_sub_col <= r_sub_col + blu5_pkg::SUB_W'(1);
            end
        end
    end

    // Bilinear weights in units of 1/25
    always_comb begin
        wi0   = blu5_pkg::SUB_FIVE - r_sub_row;
        wj0   = blu5_pkg::SUB_FIVE - r_sub_col;
        w00   = blu5_pkg::WGT_W'(wi0) * blu5_pkg::WGT_W'(wj0);
        w01   = blu5_pkg::WGT_W'(wi0) * blu5_pkg::WGT_W'(r_sub_col);
        w10   = blu5_pkg::WGT_W'(r_sub_row) * blu5_pkg::WGT_W'(wj0);
        w11   = blu5_pkg::WGT_W'(r_sub_row) * blu5_pkg::WGT_W'(r_sub_col);
        n_sum = blu5_pkg::SUM_W'(w00) * blu5_pkg::SUM_W'(i_head.p00)
              + blu5_pkg::SUM_W'(w01) * blu5_pkg::SUM_W'(i_head.p01)
              + blu5_pkg::SUM_W'(w10) * blu5_pkg::SUM_W'(i_head.p10)
              + blu5_pkg::SUM_W'(w11) * blu5_pkg::SUM_W'(i_head.p11);
    end

    // Divide by 25
    assign prod = PW'(r_s1_sum) * PW'(blu5_pkg::RECIP_25);

    // Valid bits
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_s1_vld <= 1'b0;
            r_o_vld  <= 1'b0;
        end else if (adv) begin
            r_s1_vld <= issue;
            r_o_vld  <= r_s1_vld;
        end
    end

    // Payload registers
    always_ff @(posedge i_clk) begin
        if (adv) begin
            r_s1_sum      <= n_sum;
            r_s1_row      <= r_sub_row;
            r_s1_col      <= r_sub_col;
            r_s1_cell_col <= i_head.cell_col;
            r_s1_last     <= last_pos;
            r_o_value     <= prod[blu5_pkg::RECIP_SHIFT +: blu5_pkg::PIX_W];
            r_o_row       <= r_s1_row;
            r_o_col       <= r_s1_col;
            r_o_cell_col  <= r_s1_cell_col;
            r_o_last      <= r_s1_last;
        end
    end

    assign o_valid      = r_o_vld;
    assign o_value      = r_o_value;
    assign o_sub_row    = r_o_row;
    assign o_sub_col    = r_o_col;
    assign o_cell_col   = r_o_cell_col;
    assign o_block_last = r_o_last;

endmodule

// ===== src/bilinear_upscale_by_five.sv =====
// Path: the closing pixel's beat passes front stage B, the cell queue, the sum stage
// and the output register before the cell's first output. Throughput: 25 outputs per
// closing pixel (one output per cycle while cells are queued and i_ready is high).
// The front end runs ahead of the sequencer by up to 4 queued cells.
// Reset: synchronous, active low; clears counters, queue and valids, width = 104.
// ----------------------------------------------------------------------------
// bilinear_upscale_by_five
// 5x bilinear upscaler for an 8-bit grey raster stream: front end with line
// store, cell queue, and output sequencer.
// ----------------------------------------------------------------------------
module bilinear_upscale_by_five #(
    parameter int MAX_WIDTH = 128
) (
    input  logic                                i_clk,
    input  logic                                i_rst_n,
    input  logic                                i_cfg_wr_en,
    input  logic [blu5_pkg::CFG_W-1:0]          i_cfg_wr_data,
    input  logic                                i_valid,
    output logic                                o_ready,
    input  logic [blu5_pkg::PIX_W-1:0]          i_pixel,
    input  logic                                i_frame_start,
    output logic                                o_valid,
    input  logic                                i_ready,
    output logic [blu5_pkg::PIX_W-1:0]          o_value,
    output logic [blu5_pkg::SUB_W-1:0]          o_sub_row,
    output logic [blu5_pkg::SUB_W-1:0]          o_sub_col,
    output logic [blu5_pkg::CELL_COL_W-1:0]     o_cell_col,
    output logic                                o_block_last
);

    logic [blu5_pkg::CFG_W-1:0] r_source_width;
    blu5_pkg::t_q_stat          q_stat;
    blu5_pkg::t_cell            push_cell;
    blu5_pkg::t_cell            head_cell;
    logic                       push;
    logic                       pop;

    // Width register
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_source_width <= blu5_pkg::RESET_SOURCE_WIDTH;
        end else if (i_cfg_wr_en) begin
            r_source_width <= i_cfg_wr_data;
        end
    end

    blu5_front #(
        .MAX_WIDTH (MAX_WIDTH)
    ) u_front (
        .i_clk          (i_clk),
        .i_rst_n        (i_rst_n),
        .i_source_width (r_source_width),
        .i_valid        (i_valid),
        .i_pixel        (i_pixel),
        .i_frame_start  (i_frame_start),
        .o_ready        (o_ready),
        .i_q_stat       (q_stat),
        .o_push         (push),
        .o_cell         (push_cell)
    );

    blu5_queue u_queue (
        .i_clk   (i_clk),
        .i_rst_n (i_rst_n),
        .i_push  (push),
        .i_cell  (push_cell),
        .i_pop   (pop),
        .o_head  (head_cell),
        .o_stat  (q_stat)
    );

    blu5_back u_back (
        .i_clk        (i_clk),
        .i_rst_n      (i_rst_n),
        .i_head       (head_cell),
        .i_q_stat     (q_stat),
        .o_pop        (pop),
        .o_valid      (o_valid),
        .i_ready      (i_ready),
        .o_value      (o_value),
        .o_sub_row    (o_sub_row),
        .o_sub_col    (o_sub_col),
        .o_cell_col   (o_cell_col),
        .o_block_last (o_block_last)
    );

endmodule

// ===== src/blu5_checker.sv =====
// ----------------------------------------------------------------------------
// blu5_checker
// Port-level checks of the upscaler output stream, bound to the top level.
// ----------------------------------------------------------------------------
module blu5_checker (
    input logic                                i_clk,
    input logic                                i_rst_n,
    input logic                                o_valid,
    input logic                                i_ready,
    input logic [blu5_pkg::PIX_W-1:0]          o_value,
    input logic [blu5_pkg::SUB_W-1:0]          o_sub_row,
    input logic [blu5_pkg::SUB_W-1:0]          o_sub_col,
    input logic [blu5_pkg::CELL_COL_W-1:0]     o_cell_col,
    input logic                                o_block_last
);

    // Stalled output beat holds
    a_out_hold: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        o_valid && !i_ready |=> o_valid && $stable(o_value) && $stable(o_sub_row)
            && $stable(o_sub_col) && $stable(o_cell_col) && $stable(o_block_last))
        else $error("output beat changed while stalled");

    // Sub-positions stay inside the 5x5 block
    a_sub_range: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        o_valid |-> (o_sub_row <= blu5_pkg::SUB_LAST) && (o_sub_col <= blu5_pkg::SUB_LAST))
        else $error("sub position out of range");

    // Block end flag matches the last sub-position
    a_last_pos: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        o_valid |-> o_block_last == ((o_sub_row == blu5_pkg::SUB_LAST)
            && (o_sub_col == blu5_pkg::SUB_LAST)))
        else $error("block_last on wrong sub position");

    // Reset empties the output register
    a_rst_idle: assert property (@(posedge i_clk)
        !i_rst_n |=> !o_valid)
        else $error("output valid after reset");

endmodule

bind bilinear_upscale_by_five blu5_checker u_blu5_checker (
    .i_clk        (i_clk),
    .i_rst_n      (i_rst_n),
    .o_valid      (o_valid),
    .i_ready      (i_ready),
    .o_value      (o_value),
    .o_sub_row    (o_sub_row),
    .o_sub_col    (o_sub_col),
    .o_cell_col   (o_cell_col),
    .o_block_last (o_block_last)
);

// ===== sim/tb_bilinear_upscale_by_five.sv =====
// ----------------------------------------------------------------------------
// tb_bilinear_upscale_by_five
// Self-checking bench for the 5x bilinear upscaler. A scoreboard class keeps
// its own line store and cell registers and expands each accepted source
// pixel into the 5x5 block it should close. Output beats are checked in
// order. The stimulus runs a short directed set first, then raster phases at
// several row widths, including out-of-range widths on both sides. Both
// channels idle at random, and the output side holds off long enough to fill
// the cell queue.
// ----------------------------------------------------------------------------
module tb_bilinear_upscale_by_five;
    timeunit 1ns;
    timeprecision 1ps;

    import blu5_pkg::*;

    localparam int MAX_WIDTH    = 128;
    localparam int CLK_HALF     = 5;
    localparam int RESET_CYCLES = 5;
    localparam int DRAIN_CYCLES = 12;    // margin for the pipeline to drain
    localparam int HOLD_CYCLES  = 400;   // long output hold-off
    localparam int STALL_LIMIT  = 2000;  // cycles without any beat
    localparam int MAX_REPORTS  = 10;
    localparam int NUM_PHASES   = 10;

    // One output beat
    typedef struct packed {
        logic [PIX_W-1:0]      value;
        logic [SUB_W-1:0]      sub_row;
        logic [SUB_W-1:0]      sub_col;
        logic [CELL_COL_W-1:0] cell_col;
        logic                  block_last;
    } t_out_beat;

    // ------------------------------------------------------------------------
    // Scoreboard: upscaler state and the queue of expected output beats
    // ------------------------------------------------------------------------
    class upscale_scoreboard;
        logic [CFG_W-1:0] width_reg;
        logic [PIX_W-1:0] line_store [MAX_WIDTH];
        bit               written [MAX_WIDTH];
        logic [PIX_W-1:0] left_pix;
        logic [PIX_W-1:0] upper_left_pix;
        int unsigned      col_count;
        bit               past_first_row;
        t_out_beat        expected_beats [$];
        int unsigned      mismatches;

        function new();
            width_reg      = RESET_SOURCE_WIDTH;
            left_pix       = '0;
            upper_left_pix = '0;
            col_count      = 0;
            past_first_row = 1'b0;
            mismatches     = 0;
            foreach (line_store[k]) begin
                line_store[k] = '0;
                written[k]    = 1'b0;
            end
        endfunction

        // Width register clamped to the supported range
        function int unsigned row_width();
            if (width_reg < MIN_WIDTH)
                return MIN_WIDTH;
            if (width_reg > MAX_WIDTH)
                return MAX_WIDTH;
            return width_reg;
        endfunction

        // Set when a row at the current width could read a column never stored
        function bit needs_restart();
            for (int k = 0; k < row_width(); k++) begin
                if (!written[k])
                    return 1'b1;
            end
            return 1'b0;
        endfunction

        // Accepted source pixel: queue the 5x5 block it closes, if any
        function void take_pixel(logic [PIX_W-1:0] px, logic fs);
            int unsigned w;
            int unsigned col;
            int unsigned p00, p01, p10, p11, sum;
            logic [PIX_W-1:0] above;
            t_out_beat beat;
            w = row_width();
            if (fs) begin
                col_count      = 0;
                past_first_row = 1'b0;
            end
            col = col_count;
            // count ran past a narrowed row: start a new row
            if (col >= w) begin
                col            = 0;
                past_first_row = 1'b1;
            end
            above = line_store[col];
            if (past_first_row && col >= 1) begin
                p00 = upper_left_pix;
                p01 = above;
                p10 = left_pix;
                p11 = px;
                for (int unsigned i = 0; i < 5; i++) begin
                    for (int unsigned j = 0; j < 5; j++) begin
                        sum = (5 - i) * (5 - j) * p00 + (5 - i) * j * p01
                            + i * (5 - j) * p10 + i * j * p11;
                        beat.value      = PIX_W'(sum / 25);
                        beat.sub_row    = SUB_W'(i);
                        beat.sub_col    = SUB_W'(j);
                        beat.cell_col   = CELL_COL_W'(col - 1);
                        beat.block_last = (i == SUB_LAST) && (j == SUB_LAST);
                        expected_beats.push_back(beat);
                    end
                end
            end
            upper_left_pix  = above;
            line_store[col] = px;
            written[col]    = 1'b1;
            left_pix        = px;
            col++;
            if (col >= w) begin
                col_count      = 0;
                past_first_row = 1'b1;
            end else begin
                col_count = col;
            end
        endfunction

        // Accepted output beat against the oldest expectation
        function void check_beat(t_out_beat got);
            t_out_beat want;
            if (expected_beats.size() == 0) begin
                mismatches++;
                if (mismatches <= MAX_REPORTS)
                    $display("[%0t] unexpected beat: value=%0d sub=%0d,%0d col=%0d last=%0b",
                             $realtime, got.value, got.sub_row, got.sub_col, got.cell_col,
                             got.block_last);
                return;
            end
            want = expected_beats.pop_front();
            if (got.value !== want.value || got.sub_row !== want.sub_row ||
                got.sub_col !== want.sub_col || got.cell_col !== want.cell_col ||
                got.block_last !== want.block_last) begin
                mismatches++;
                if (mismatches <= MAX_REPORTS)
                    $display({"[%0t] mismatch: exp value=%0d sub=%0d,%0d col=%0d last=%0b",
                              " | got value=%0d sub=%0d,%0d col=%0d last=%0b"},
                             $realtime, want.value, want.sub_row, want.sub_col,
                             want.cell_col, want.block_last, got.value, got.sub_row,
                             got.sub_col, got.cell_col, got.block_last);
            end
        endfunction
    endclass

    // ------------------------------------------------------------------------
    // Signals
    // ------------------------------------------------------------------------
    logic                  i_clk         = 1'b0;
    logic                  i_rst_n       = 1'b0;
    logic                  i_cfg_wr_en   = 1'b0;
    logic [CFG_W-1:0]      i_cfg_wr_data = '0;
    logic                  i_valid       = 1'b0;
    logic                  o_ready;
    logic [PIX_W-1:0]      i_pixel       = '0;
    logic                  i_frame_start = 1'b0;
    logic                  o_valid;
    logic                  i_ready       = 1'b0;
    logic [PIX_W-1:0]      o_value;
    logic [SUB_W-1:0]      o_sub_row;
    logic [SUB_W-1:0]      o_sub_col;
    logic [CELL_COL_W-1:0] o_cell_col;
    logic                  o_block_last;

    upscale_scoreboard sb;
    int unsigned       max_gap          = 9;
    bit                hold_off_request = 1'b0;
    int unsigned       idle_cycles      = 0;

    // Corner values for the directed width-2 rows
    logic [PIX_W-1:0] corner_pix [12] = '{8'd0,   8'd255, 8'd255, 8'd0,
                                          8'd255, 8'd255, 8'd255, 8'd255,
                                          8'd0,   8'd0,   8'd0,   8'd0};

    // Random phases: written width and number of source pixels
    logic [CFG_W-1:0] phase_width [NUM_PHASES] = '{8'd1, 8'd3, 8'd16, 8'd5, 8'd2,
                                                   8'd7, 8'd255, 8'd128, 8'd129, 8'd6};
    int               phase_items [NUM_PHASES] = '{16, 16, 24, 16, 12,
                                                   16, 20, 10, 6, 14};

    bilinear_upscale_by_five #(
        .MAX_WIDTH(MAX_WIDTH)
    ) i_dut (
        .i_clk        (i_clk),
        .i_rst_n      (i_rst_n),
        .i_cfg_wr_en  (i_cfg_wr_en),
        .i_cfg_wr_data(i_cfg_wr_data),
        .i_valid      (i_valid),
        .o_ready      (o_ready),
        .i_pixel      (i_pixel),
        .i_frame_start(i_frame_start),
        .o_valid      (o_valid),
        .i_ready      (i_ready),
        .o_value      (o_value),
        .o_sub_row    (o_sub_row),
        .o_sub_col    (o_sub_col),
        .o_cell_col   (o_cell_col),
        .o_block_last (o_block_last)
    );

    // Clock
    initial begin
        forever #CLK_HALF i_clk = ~i_clk;
    end

    // Watchdog: cycles with no beat on either channel
    always @(posedge i_clk) begin
        if (!i_rst_n || (i_valid && o_ready) || (o_valid && i_ready))
            idle_cycles <= 0;
        else
            idle_cycles <= idle_cycles + 1;
        if (idle_cycles >= STALL_LIMIT) begin
            $display("Regression FAIL");
            $finish;
        end
    end

    // ------------------------------------------------------------------------
    // Input side
    // ------------------------------------------------------------------------
    function automatic logic [PIX_W-1:0] draw_pixel();
        case ($urandom_range(0, 7))
            0:       return '0;
            1:       return '1;
            default: return PIX_W'($urandom);
        endcase
    endfunction

    // Offer one pixel beat after a random gap, return once accepted
    task automatic send_pixel(input logic [PIX_W-1:0] px, input logic fs);
        int unsigned gap;
        gap = $urandom_range(0, max_gap);
        if (gap != 0) begin
            i_valid <= 1'b0;
            repeat (gap) @(posedge i_clk);
        end
        i_valid       <= 1'b1;
        i_pixel       <= px;
        i_frame_start <= fs;
        do @(posedge i_clk); while (!o_ready);
        sb.take_pixel(px, fs);
    endtask

    // Wait until every expected beat is out and the front end is quiet
    task automatic wait_drained();
        while (sb.expected_beats.size() != 0) @(posedge i_clk);
        repeat (DRAIN_CYCLES) @(posedge i_clk);
    endtask

    task automatic write_width(input logic [CFG_W-1:0] w);
        i_cfg_wr_en   <= 1'b1;
        i_cfg_wr_data <= w;
        @(posedge i_clk);
        i_cfg_wr_en   <= 1'b0;
        sb.width_reg = w;
    endtask

    task automatic run_directed();
        max_gap = 9;
        // width 2: cells built from the extremes, all-high and all-low among them
        wait_drained();
        write_width(8'd2);
        for (int k = 0; k < 12; k++)
            send_pixel(corner_pix[k], k == 0);
        // new frame started in the middle of the stream
        send_pixel(8'd7, 1'b1);
        send_pixel(8'd9, 1'b0);
        send_pixel(8'd200, 1'b0);
        send_pixel(8'd100, 1'b0);
        i_valid <= 1'b0;
        // width 4, stopping two pixels into the second row
        wait_drained();
        write_width(8'd4);
        for (int k = 0; k < 6; k++)
            send_pixel(draw_pixel(), k == 0);
        i_valid <= 1'b0;
        // width 0 acts as 2; the column count is already past the new row end
        wait_drained();
        write_width(8'd0);
        for (int k = 0; k < 3; k++)
            send_pixel(draw_pixel(), 1'b0);
        i_valid <= 1'b0;
    endtask

    task automatic run_phase(input logic [CFG_W-1:0] w, input int n);
        logic fs;
        wait_drained();
        write_width(w);
        max_gap = ($urandom_range(0, 3) == 0) ? 0 : 9;
        for (int k = 0; k < n; k++) begin
            // restart the frame when the new width reaches unstored columns
            if (k == 0)
                fs = sb.needs_restart() || ($urandom_range(0, 3) == 0);
            else
                fs = (sb.row_width() <= 16) && ($urandom_range(0, 29) == 0);
            send_pixel(draw_pixel(), fs);
        end
        i_valid <= 1'b0;
    endtask

    // ------------------------------------------------------------------------
    // Output side: random ready gaps, long hold-off on request
    // ------------------------------------------------------------------------
    initial begin : output_sink
        int unsigned gap;
        t_out_beat   got;
        while (!i_rst_n) @(posedge i_clk);
        forever begin
            if (hold_off_request) begin
                hold_off_request = 1'b0;
                gap = HOLD_CYCLES;
            end else begin
                gap = $urandom_range(0, max_gap);
            end
            if (gap != 0) begin
                i_ready <= 1'b0;
                repeat (gap) @(posedge i_clk);
            end
            i_ready <= 1'b1;
            do @(posedge i_clk); while (!o_valid);
            got.value      = o_value;
            got.sub_row    = o_sub_row;
            got.sub_col    = o_sub_col;
            got.cell_col   = o_cell_col;
            got.block_last = o_block_last;
            sb.check_beat(got);
        end
    end

    // ------------------------------------------------------------------------
    // Main sequence
    // ------------------------------------------------------------------------
    initial begin : main_seq
        sb = new();
        repeat (RESET_CYCLES) @(posedge i_clk);
        i_rst_n <= 1'b1;
        @(posedge i_clk);

        run_directed();
        for (int p = 0; p < NUM_PHASES; p++) begin
            // fill the cell queue while the output side is held off; the hold
            // starts on the first beat of this phase, so drain the last one first
            if (p == 2 || p == 5) begin
                wait_drained();
                hold_off_request = 1'b1;
            end
            run_phase(phase_width[p], phase_items[p]);
        end

        wait_drained();
        if (sb.mismatches == 0 && sb.expected_beats.size() == 0) begin
            $display("Regression PASS");
        end else begin
            $display("Regression FAIL");
        end
        $finish;
    end

endmodule
